// ===== hdl/md5_pkg.sv =====
// Package for the MD5 message digest block.
// Holds the request and response types, the working-word type, the initial
// chaining values, the round constants and the per-round rotate amounts.
`timescale 1ns / 1ps

package md5_pkg;

    // One input request: a message byte, its valid flag and end of message.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       msg_last;
    } t_md5_in;

    // One result: half of the digest.
    typedef struct packed {
        logic [63:0] digest_half;
        logic        half_last;
    } t_md5_out;

    // The four 32-bit words A, B, C and D.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_md5_words;

    localparam logic [31:0] MD5_INIT_A = 32'h6745_2301;
    localparam logic [31:0] MD5_INIT_B = 32'hEFCD_AB89;
    localparam logic [31:0] MD5_INIT_C = 32'h98BA_DCFE;
    localparam logic [31:0] MD5_INIT_D = 32'h1032_5476;

    localparam t_md5_words MD5_INIT_WORDS = '{
        a: MD5_INIT_A, b: MD5_INIT_B, c: MD5_INIT_C, d: MD5_INIT_D
    };

    localparam logic [7:0] MD5_PAD_MARK   = 8'h80;
    localparam logic [5:0] MD5_LEN_OFFSET = 6'd56;
    localparam logic [5:0] MD5_LAST_BYTE  = 6'd63;
    localparam logic [5:0] MD5_LAST_ROUND = 6'd63;
    localparam int         MD5_WORDS      = 16;

    // Rotate amounts, indexed by round group and the low two round bits.
    localparam logic [4:0] MD5_SHIFT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // Additive constant of each round.
    function automatic logic [31:0] md5_k(input logic [5:0] round_idx);
        logic [31:0] k;
        case (round_idx)
            6'd0:  k = 32'hD76AA478;
            6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB;
            6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF;
            6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613;
            6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8;
            6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1;
            6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122;
            6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E;
            6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562;
            6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51;
            6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681;
            6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6;
            6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87;
            6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905;
            6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9;
            6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942;
            6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122;
            6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44;
            6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60;
            6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6;
            6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085;
            6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039;
            6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8;
            6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244;
            6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7;
            6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3;
            6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D;
            6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F;
            6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314;
            6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82;
            6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB;
            6'd63: k = 32'hEB86D391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Message word index used by a round.
    function automatic logic [3:0] md5_g(input logic [5:0] round_idx);
        logic [3:0] j;
        logic [3:0] g;
        j = round_idx[3:0];
        case (round_idx[5:4])
            2'd0:    g = j;
            2'd1:    g = j * 4'd5 + 4'd1;
            2'd2:    g = j * 4'd3 + 4'd5;
            default: g = j * 4'd7;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/md5_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone: depends on nothing else in the project.
`timescale 1ns / 1ps

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/md5_round.sv =====
// MD5 round unit: one round of the compression function per use.
// Depends on md5_pkg for the word type, round constants and rotate amounts.
`timescale 1ns / 1ps

module md5_round (
    input  md5_pkg::t_md5_words i_work,
    input  logic [5:0]          i_round,
    input  logic [31:0]         i_w,
    output md5_pkg::t_md5_words o_work,
    output logic [3:0]          o_next_g
);

    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  shamt;
    logic [63:0] rot_wide;
    logic [5:0]  next_round;

    always_comb begin
        case (i_round[5:4])
            2'd0:    f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            2'd1:    f = (i_work.b & i_work.d) | (i_work.c & ~i_work.d);
            2'd2:    f = i_work.b ^ i_work.c ^ i_work.d;
            default: f = i_work.c ^ (i_work.b | ~i_work.d);
        endcase
    end

    assign sum      = i_work.a + f + md5_k(i_round) + i_w;
    assign shamt    = MD5_SHIFT[{i_round[5:4], i_round[1:0]}];
    // Rotate left: the upper half of the doubled word shifted left.
    assign rot_wide = {sum, sum} << shamt;

    assign o_work.a = i_work.d;
    assign o_work.b = i_work.b + rot_wide[63:32];
    assign o_work.c = i_work.b;
    assign o_work.d = i_work.c;

    assign next_round = i_round + 6'd1;
    assign o_next_g   = md5_g(next_round);

endmodule

// ===== hdl/md5_message_digest.sv =====
// MD5 message digest, one message byte per request. A byte that does not complete a
// 64-byte block is only stored; one that completes it passes a prefetch state, the
// rounds on the single round unit and a chaining-word add. Bytes are taken at 1 byte
// per cycle while o_stall is low. A last request adds padding, one byte per
// cycle outside compressions and one or two compressions before the two digest halves.
// Reset (i_rst_n, synchronous, active low) restores the initial chaining words at once.
`timescale 1ns / 1ps

module md5_message_digest (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  md5_pkg::t_md5_in  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output md5_pkg::t_md5_out o_rsp
);

    import md5_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE     = 9'b0_0000_0001,
        ST_PAD_MARK = 9'b0_0000_0010,
        ST_PAD_ZERO = 9'b0_0000_0100,
        ST_PAD_LEN  = 9'b0_0000_1000,
        ST_PRIME    = 9'b0_0001_0000,
        ST_COMP     = 9'b0_0010_0000,
        ST_FIN      = 9'b0_0100_0000,
        ST_OUT0     = 9'b0_1000_0000,
        ST_OUT1     = 9'b1_0000_0000
    } t_state;

    localparam int WordAddrW = $clog2(MD5_WORDS);

    t_state     r_state, n_state;
    t_state     r_resume, n_resume;
    t_md5_words r_chain, n_chain;
    t_md5_words r_work, n_work;
    logic [63:0] r_count, n_count;
    logic [5:0]  r_fill, n_fill;
    logic [23:0] r_acc, n_acc;
    logic [5:0]  r_round, n_round;

    logic                 push_en;
    logic [7:0]           push_data;
    logic                 block_full;
    logic                 ram_we;
    logic [WordAddrW-1:0] ram_raddr;
    logic [31:0]          ram_rdata;
    t_md5_words           round_out;
    logic [3:0]           next_g;

    // Byte reversal: the digest is printed with the low byte of each word first.
    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // The block buffer holds 16 little-endian 32-bit words. Bytes are gathered
    // in r_acc and the word is written when its fourth byte arrives, so the
    // round unit can read a whole message word per cycle.
    md5_ram #(
        .WIDTH(32),
        .DEPTH(MD5_WORDS)
    ) u_block (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata ({push_data, r_acc}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The single round unit, reused for all 64 rounds of a block.
    md5_round u_round (
        .i_work   (r_work),
        .i_round  (r_round),
        .i_w      (ram_rdata),
        .o_work   (round_out),
        .o_next_g (next_g)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT0) || (r_state == ST_OUT1);

    // Both halves come straight from the chaining words, which hold still
    // while a result waits.
    always_comb begin
        if (r_state == ST_OUT1) begin
            o_rsp.digest_half = {byte_swap(r_chain.c), byte_swap(r_chain.d)};
            o_rsp.half_last   = 1'b1;
        end else begin
            o_rsp.digest_half = {byte_swap(r_chain.a), byte_swap(r_chain.b)};
            o_rsp.half_last   = 1'b0;
        end
    end

    assign ram_we     = push_en && (r_fill[1:0] == 2'b11);
    assign block_full = push_en && (r_fill == MD5_LAST_BYTE);
    // The read is issued in the cycle before the round that uses the word.
    assign ram_raddr  = (r_state == ST_PRIME) ? '0 : next_g;

    always_comb begin
        n_state   = r_state;
        n_resume  = r_resume;
        n_chain   = r_chain;
        n_work    = r_work;
        n_count   = r_count;
        n_round   = r_round;
        push_en   = 1'b0;
        push_data = 8'h00;

        case (r_state)
            ST_IDLE: begin
                // A byte is taken into the message before the end is handled.
                if (i_valid) begin
                    if (i_req.byte_valid) begin
                        push_en   = 1'b1;
                        push_data = i_req.data_byte;
                        n_count   = r_count + 64'd8;
                    end
                    if (block_full) begin
                        n_state  = ST_PRIME;
                        n_resume = i_req.msg_last ? ST_PAD_MARK : ST_IDLE;
                    end else if (i_req.msg_last) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                push_en   = 1'b1;
                push_data = MD5_PAD_MARK;
                n_resume  = ST_PAD_ZERO;
                n_state   = block_full ? ST_PRIME : ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (r_fill == MD5_LEN_OFFSET) begin
                    n_state = ST_PAD_LEN;
                end else begin
                    push_en  = 1'b1;
                    n_resume = ST_PAD_ZERO;
                    if (block_full) begin
                        n_state = ST_PRIME;
                    end
                end
            end
            ST_PAD_LEN: begin
                // The bit count is shifted out low byte first; it is no longer
                // needed as a count once the message has ended.
                push_en   = 1'b1;
                push_data = r_count[7:0];
                n_count   = {8'h00, r_count[63:8]};
                if (block_full) begin
                    n_state  = ST_PRIME;
                    n_resume = ST_OUT0;
                end
            end
            ST_PRIME: begin
                n_work  = r_chain;
                n_round = '0;
                n_state = ST_COMP;
            end
            ST_COMP: begin
                n_work  = round_out;
                n_round = r_round + 6'd1;
                if (r_round == MD5_LAST_ROUND) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                n_state   = r_resume;
            end
            ST_OUT0: begin
                if (!i_stall) begin
                    n_state = ST_OUT1;
                end
            end
            ST_OUT1: begin
                // After the second half the block starts a fresh message.
                if (!i_stall) begin
                    n_state = ST_IDLE;
                    n_chain = MD5_INIT_WORDS;
                    n_count = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Byte gathering and fill index follow from the push request.
    always_comb begin
        n_acc  = r_acc;
        n_fill = r_fill;
        if (push_en) begin
            n_fill = r_fill + 6'd1;
            case (r_fill[1:0])
                2'd0:    n_acc[7:0]   = push_data;
                2'd1:    n_acc[15:8]  = push_data;
                2'd2:    n_acc[23:16] = push_data;
                default: n_acc        = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_resume <= ST_IDLE;
            r_chain  <= MD5_INIT_WORDS;
            r_count  <= '0;
            r_fill   <= '0;
            r_round  <= '0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_chain  <= n_chain;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_round  <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_acc  <= n_acc;
    end

endmodule
